// ===== design/utf8gi_pkg.sv =====
// Package for the UTF-8 decoder with glyph table lookup.
// Holds the scan state type, command and status codes, byte-class masks and widths.
// No dependencies; imported by utf8_to_glyph_index and the testbench.
package utf8gi_pkg;

  // Lookup sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Input word commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  // Result status codes
  localparam logic STAT_FOUND    = 1'b0;
  localparam logic STAT_NOTFOUND = 1'b1;

  // Byte classes
  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;

  localparam int ENTRY_COUNT_W = 11;
  localparam int ADDR_IN_W     = 10;
  localparam int CODE_W        = 16;
  localparam int ACCUM_W       = 21;

endpackage

// ===== design/utf8_to_glyph_index.sv =====
// UTF-8 byte decoder and glyph table lookup, top level.
// A load word, or a byte word that ends no character, leaves the block idle and
// ready. A decoded character scans the table: one read per cycle into the read
// register, then the compare, until a hit or the end of min(entry_count,
// TABLE_DEPTH) entries. One lookup at a time: input is taken again once the
// result is in the output register, so a lookup holds the input for the whole
// scan plus any output stall.
// Reset (synchronous, rst_n low) clears the decoder, entry_count and control
// state; table contents stay undefined until loaded. Depends on utf8gi_pkg.
module utf8_to_glyph_index #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [utf8gi_pkg::ENTRY_COUNT_W-1:0] cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [utf8gi_pkg::ADDR_IN_W-1:0] in_entry_addr,
  input  logic [utf8gi_pkg::CODE_W-1:0]    in_entry_code,
  input  logic [7:0]  in_byte_value,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic [utf8gi_pkg::ADDR_IN_W-1:0] out_glyph_index,
  output logic [utf8gi_pkg::CODE_W-1:0]    out_code_point
);
  import utf8gi_pkg::*;

  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int LW   = (CW > ENTRY_COUNT_W) ? CW : ENTRY_COUNT_W;
  localparam int CMPW = (AW > ADDR_IN_W) ? AW + 1 : ADDR_IN_W + 1;

  // Control and decoder state
  state_t                   state_r, state_nxt;
  logic [ENTRY_COUNT_W-1:0] entry_count_r;
  logic [1:0]               pending_r, pending_nxt;
  logic [ACCUM_W-1:0]       accum_r, accum_nxt;
  logic [CW-1:0]            scan_addr_r;
  logic [CW-1:0]            limit_r;
  logic                     rd_vld_r;
  logic                     found_r;
  logic                     out_valid_r;

  // Payload registers
  logic [CODE_W-1:0]        cp_r;
  logic [AW-1:0]            rd_idx_r;
  logic [AW-1:0]            hit_idx_r;
  logic [CODE_W-1:0]        rd_data_r;
  logic                     out_status_r;
  logic [ADDR_IN_W-1:0]     out_index_r;
  logic [CODE_W-1:0]        out_code_r;

  // Glyph table
  logic [CODE_W-1:0]        glyph_mem [TABLE_DEPTH];

  logic              in_acc;
  logic              byte_acc;
  logic [CODE_W-1:0] dec_cp;
  logic              start_scan;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic              rd_en;
  logic              hit;
  logic              scan_end;
  logic              out_free;
  logic              out_load;
  logic [LW-1:0]     count_ext;
  logic [LW-1:0]     limit_sel;

  assign in_acc   = in_valid && in_ready;
  assign byte_acc = in_acc && (in_cmd == CMD_BYTE);
  assign out_free = !out_valid_r || out_ready;

  // UTF-8 byte decode: continuation bytes are not checked
  always_comb begin
    dec_cp      = '0;
    pending_nxt = pending_r;
    accum_nxt   = accum_r;
    if ((in_byte_value & ASCII_MASK) == 8'h00) begin
      pending_nxt = 2'd0;
      dec_cp      = {8'd0, in_byte_value};
    end else if (pending_r == 2'd0) begin
      if ((in_byte_value & LEAD2_MASK) == LEAD2_CODE) begin
        accum_nxt   = {10'd0, in_byte_value[4:0], 6'd0};
        pending_nxt = 2'd1;
      end else if ((in_byte_value & LEAD3_MASK) == LEAD3_CODE) begin
        accum_nxt   = {5'd0, in_byte_value[3:0], 12'd0};
        pending_nxt = 2'd2;
      end else if ((in_byte_value & LEAD4_MASK) == LEAD4_CODE) begin
        accum_nxt   = {in_byte_value[2:0], 18'd0};
        pending_nxt = 2'd3;
      end else begin
        // stray byte passes through raw
        dec_cp = {8'd0, in_byte_value};
      end
    end else begin
      case (pending_r)
        2'd3: begin
          accum_nxt   = accum_r | {3'd0, in_byte_value[5:0], 12'd0};
          pending_nxt = 2'd2;
        end
        2'd2: begin
          accum_nxt   = accum_r | {9'd0, in_byte_value[5:0], 6'd0};
          pending_nxt = 2'd1;
        end
        default: begin
          accum_nxt   = accum_r | {15'd0, in_byte_value[5:0]};
          pending_nxt = 2'd0;
          dec_cp      = accum_nxt[CODE_W-1:0];
        end
      endcase
    end
  end

  assign start_scan = byte_acc && (dec_cp != '0);

  // Scan length: entry_count clipped to the table depth
  assign count_ext = LW'(entry_count_r);
  assign limit_sel = (count_ext > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : count_ext;

  // Table write port; loads beyond the table are dropped
  assign mem_we = in_acc && (in_cmd == CMD_LOAD) &&
                  (CMPW'(in_entry_addr) < CMPW'(TABLE_DEPTH));
  assign mem_wa = AW'(in_entry_addr);

  // Compare stage on the registered read data
  assign hit      = rd_vld_r && (rd_data_r == cp_r);
  assign scan_end = hit || (scan_addr_r >= limit_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start_scan) state_nxt = ST_SCAN;
      ST_SCAN: if (scan_end)   state_nxt = ST_DONE;
      ST_DONE: if (out_free)   state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs; table writes happen only in idle, reads only in scan
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_SCAN: rd_en    = !hit && (scan_addr_r < limit_r);
      ST_DONE: out_load = out_free;
      default: ;
    endcase
  end

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      glyph_mem[mem_wa] <= in_entry_code;
    end
    if (rd_en) begin
      rd_data_r <= glyph_mem[scan_addr_r[AW-1:0]];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      entry_count_r <= '0;
      pending_r     <= 2'd0;
      accum_r       <= '0;
      scan_addr_r   <= '0;
      limit_r       <= '0;
      rd_vld_r      <= 1'b0;
      found_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        entry_count_r <= cfg_wdata;
      end
      if (byte_acc) begin
        pending_r <= pending_nxt;
        accum_r   <= accum_nxt;
      end
      if (start_scan) begin
        scan_addr_r <= '0;
        limit_r     <= CW'(limit_sel);
        rd_vld_r    <= 1'b0;
        found_r     <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        rd_vld_r <= rd_en;
        if (rd_en) begin
          scan_addr_r <= scan_addr_r + CW'(1);
        end
        if (hit) begin
          found_r <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (start_scan) begin
      cp_r <= dec_cp;
    end
    if (rd_en) begin
      rd_idx_r <= scan_addr_r[AW-1:0];
    end
    if (state_r == ST_SCAN && hit) begin
      hit_idx_r <= rd_idx_r;
    end
    if (out_load) begin
      out_status_r <= found_r ? STAT_FOUND : STAT_NOTFOUND;
      out_index_r  <= found_r ? ADDR_IN_W'(hit_idx_r) : '0;
      out_code_r   <= cp_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_glyph_index = out_index_r;
  assign out_code_point  = out_code_r;

  // Checks
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !mem_we)
    else $error("table written during a lookup");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_addr_r <= limit_r))
    else $error("scan address ran past the limit");

  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && found_r) |-> (CW'(hit_idx_r) < limit_r))
    else $error("hit index outside the scanned range");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result word raised outside lookup completion");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && !rd_en && !rd_vld_r) |=> (state_r == ST_DONE))
    else $error("scan stalled with no read in flight");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for utf8_to_glyph_index: UTF-8 decode plus glyph table scan.
// Directed and random text phases are checked against set values or a predictor.
// Depends on utf8gi_pkg and the utf8_to_glyph_index RTL.
`timescale 1ns / 1ps

module testbench;
  import utf8gi_pkg::*;

  localparam int TBL_DEPTH = 1024;

  typedef struct packed {
    logic        status;
    logic [9:0]  glyph_index;
    logic [15:0] code_point;
  } glyph_hit_t;

  // how a directed row is checked
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_HIT} row_check_t;

  // idle patterns of the two channels
  typedef enum logic [1:0] {PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

  typedef struct {
    logic        cmd;
    logic [9:0]  addr;
    logic [15:0] code;
    logic [7:0]  bval;
    row_check_t  chk;
    glyph_hit_t  hit;
  } text_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ENTRY_COUNT_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = CMD_BYTE;
  logic [ADDR_IN_W-1:0] in_entry_addr = '0;
  logic [CODE_W-1:0] in_entry_code = '0;
  logic [7:0] in_byte_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_status;
  logic [ADDR_IN_W-1:0] out_glyph_index;
  logic [CODE_W-1:0] out_code_point;

  // predictor state
  logic [15:0] glyph_tbl [TBL_DEPTH];
  bit          tbl_written [TBL_DEPTH];
  logic [1:0]  seq_left = '0;
  logic [20:0] seq_accum = '0;
  logic [10:0] entry_lim = '0;

  glyph_hit_t expected_glyphs [$];
  text_row_t  directed_rows [$];
  int error_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  utf8_to_glyph_index #(.TABLE_DEPTH(TBL_DEPTH)) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_entry_addr   (in_entry_addr),
    .in_entry_code   (in_entry_code),
    .in_byte_value   (in_byte_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_glyph_index (out_glyph_index),
    .out_code_point  (out_code_point)
  );

  always #5 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // result checker: oldest expectation first
  always @(posedge clk) begin : check_results
    glyph_hit_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_glyphs.size() == 0) begin
        $display("%0t: unexpected result status %0d index %0d code %h", $time,
                 out_status, out_glyph_index, out_code_point);
        error_count++;
      end else begin
        want = expected_glyphs.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
          error_count++;
        end
        if (out_glyph_index !== want.glyph_index) begin
          $display("%0t: glyph_index expected %0d, got %0d", $time,
                   want.glyph_index, out_glyph_index);
          error_count++;
        end
        if (out_code_point !== want.code_point) begin
          $display("%0t: code_point expected %h, got %h", $time,
                   want.code_point, out_code_point);
          error_count++;
        end
      end
    end
  end

  // Predictor: applies one word to the table/decoder copy, returns 1 on a lookup result
  function automatic bit predict_glyph(input logic cmd, input logic [9:0] addr,
                                       input logic [15:0] code, input logic [7:0] b,
                                       output glyph_hit_t hit);
    logic [15:0] cp;
    int scan_len;
    hit = '0;
    cp = '0;
    if (cmd == CMD_LOAD) begin
      glyph_tbl[addr] = code;
      tbl_written[addr] = 1'b1;
      return 1'b0;
    end
    // byte decode
    if ((b & ASCII_MASK) == 8'h00) begin
      seq_left = 2'd0;
      cp = {8'h00, b};
    end else if (seq_left == 2'd0) begin
      if ((b & LEAD2_MASK) == LEAD2_CODE) begin
        seq_accum = {10'd0, b[4:0], 6'd0};
        seq_left = 2'd1;
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
        seq_accum = {5'd0, b[3:0], 12'd0};
        seq_left = 2'd2;
      end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
        seq_accum = {b[2:0], 18'd0};
        seq_left = 2'd3;
      end else begin
        cp = {8'h00, b};
      end
    end else begin
      // continuation, unchecked: low 6 bits land by position
      seq_accum = seq_accum | (21'(b[5:0]) << (6 * (seq_left - 1)));
      seq_left = seq_left - 2'd1;
      if (seq_left == 2'd0) cp = seq_accum[15:0];
    end
    if (cp == 16'h0000) return 1'b0;
    // lowest matching index within the first entry_count entries, clipped to the depth
    hit = '{STAT_NOTFOUND, 10'd0, cp};
    scan_len = (entry_lim > TBL_DEPTH) ? TBL_DEPTH : int'(entry_lim);
    for (int i = 0; i < scan_len; i++) begin
      if (glyph_tbl[i] === cp) begin
        hit.status = STAT_FOUND;
        hit.glyph_index = i[9:0];
        return 1'b1;
      end
    end
    return 1'b1;
  endfunction

  // Present one word, wait for the handshake, then predict it
  task automatic send_word(input logic cmd, input logic [9:0] addr, input logic [15:0] code,
                           input logic [7:0] b, output bit has_res, output glyph_hit_t hit);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_entry_addr <= addr;
    in_entry_code <= code;
    in_byte_value <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    has_res = predict_glyph(cmd, addr, code, b, hit);
  endtask

  task automatic send_checked(input logic cmd, input logic [9:0] addr,
                              input logic [15:0] code, input logic [7:0] b);
    bit has_res;
    glyph_hit_t hit;
    send_word(cmd, addr, code, b, has_res, hit);
    if (has_res) expected_glyphs.push_back(hit);
  endtask

  // entry_count write once every result is out and trailing words have settled
  task automatic write_entry_count(input logic [10:0] value);
    in_valid <= 1'b0;
    while (expected_glyphs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    entry_lim = value;
  endtask

  task automatic put_load(input logic [9:0] addr, input logic [15:0] code);
    directed_rows.push_back('{CMD_LOAD, addr, code, 8'h00, CHK_NONE, '0});
  endtask

  task automatic put_byte(input logic [7:0] b, input row_check_t chk, input logic st,
                          input logic [9:0] idx, input logic [15:0] cp);
    directed_rows.push_back('{CMD_BYTE, 10'd0, 16'h0000, b, chk, '{st, idx, cp}});
  endtask

  // One random phase: new entry_count, table filled below it, then mostly valid text
  task automatic run_text_phase(input logic [10:0] lim, input pace_t pace, input int n_words);
    int fill;
    int sent;
    int r;
    int len;
    logic [20:0] v;
    logic [7:0] lead;
    logic [15:0] c;
    logic [9:0] a;
    logic [1:0] top;
    write_entry_count(lim);
    case (pace)
      PACE_FREE:       begin send_idle_pct = 0;  stall_pct = 0;  end
      PACE_SEND_IDLE:  begin send_idle_pct = 46; stall_pct = 0;  end
      PACE_RECV_STALL: begin send_idle_pct = 0;  stall_pct = 46; end
      default:         begin send_idle_pct = 37; stall_pct = 37; end
    endcase
    fill = (lim > TBL_DEPTH) ? TBL_DEPTH : int'(lim);
    // no scan may touch an entry that was never loaded
    for (int e = 0; e < fill; e++) begin
      if (!tbl_written[e]) send_checked(CMD_LOAD, e[9:0], 16'($urandom), 8'($urandom));
    end
    sent = 0;
    while (sent < n_words) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        // table load, sometimes a duplicate of a live entry
        a = $urandom_range(0, 1) ? 10'($urandom) : 10'($urandom_range(0, fill > 0 ? fill - 1 : 0));
        c = 16'($urandom);
        if (fill > 1 && $urandom_range(0, 3) == 0) c = glyph_tbl[$urandom_range(0, fill - 1)];
        send_checked(CMD_LOAD, a, c, 8'($urandom));
        sent++;
      end else if (r < 18) begin
        // raw noise byte
        send_checked(CMD_BYTE, 10'($urandom), 16'($urandom), 8'($urandom));
        sent++;
      end else if (r < 22) begin
        // lead byte cut off by ASCII
        send_checked(CMD_BYTE, 10'($urandom), 16'($urandom), 8'($urandom_range(8'hC0, 8'hF7)));
        send_checked(CMD_BYTE, 10'($urandom), 16'($urandom), 8'($urandom_range(0, 8'h7F)));
        sent += 2;
      end else begin
        // character, mostly well-formed and mostly one that is in the table
        if (fill > 0 && $urandom_range(0, 9) < 6) v = {5'd0, glyph_tbl[$urandom_range(0, fill - 1)]};
        else v = 21'($urandom_range(0, 16'hFFFF));
        len = (v < 21'h80) ? 1 : (v < 21'h800) ? 2 : 3;
        if ($urandom_range(0, 4) == 0) len = $urandom_range(len, 4);
        if (len == 4) v[20:16] = 5'($urandom);
        case (len)
          1:       lead = {1'b0, v[6:0]};
          2:       lead = {3'b110, v[10:6]};
          3:       lead = {4'b1110, v[15:12]};
          default: lead = {5'b11110, v[20:18]};
        endcase
        send_checked(CMD_BYTE, 10'($urandom), 16'($urandom), lead);
        for (int k = len - 2; k >= 0; k--) begin
          top = ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'b10;
          send_checked(CMD_BYTE, 10'($urandom), 16'($urandom), {top, v[6*k +: 6]});
        end
        sent += len;
      end
    end
  endtask

  // Main sequence
  initial begin
    bit has_res;
    glyph_hit_t hit;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: small table, duplicate code at 0 and 2, top entry outside the count
    write_entry_count(11'd4);
    put_load(10'd0, 16'h0041);
    put_load(10'd1, 16'h00E9);
    put_load(10'd2, 16'h0041);
    put_load(10'd3, 16'hF600);
    put_load(10'd1023, 16'hFFFF);
    put_byte(8'h00, CHK_NONE, STAT_NOTFOUND, 10'd0, 16'h0000);
    put_byte(8'h80, CHK_HIT, STAT_NOTFOUND, 10'd0, 16'h0080);
    put_byte(8'hFF, CHK_HIT, STAT_NOTFOUND, 10'd0, 16'h00FF);
    // ASCII aborts an open sequence
    put_byte(8'hC3, CHK_NONE, STAT_NOTFOUND, 10'd0, 16'h0000);
    put_byte(8'h41, CHK_HIT, STAT_FOUND, 10'd0, 16'h0041);
    put_byte(8'hC3, CHK_NONE, STAT_NOTFOUND, 10'd0, 16'h0000);
    put_byte(8'hA9, CHK_HIT, STAT_FOUND, 10'd1, 16'h00E9);
    put_byte(8'hE2, CHK_MODEL, STAT_NOTFOUND, 10'd0, 16'h0000);
    put_byte(8'h82, CHK_MODEL, STAT_NOTFOUND, 10'd0, 16'h0000);
    put_byte(8'hAC, CHK_HIT, STAT_NOTFOUND, 10'd0, 16'h20AC);
    // 4-byte form, truncated to 16 bits
    put_byte(8'hF0, CHK_MODEL, STAT_NOTFOUND, 10'd0, 16'h0000);
    put_byte(8'h9F, CHK_MODEL, STAT_NOTFOUND, 10'd0, 16'h0000);
    put_byte(8'h98, CHK_MODEL, STAT_NOTFOUND, 10'd0, 16'h0000);
    put_byte(8'h80, CHK_MODEL, STAT_NOTFOUND, 10'd0, 16'h0000);
    // lead bytes inside a sequence act as continuations
    put_byte(8'hE0, CHK_NONE, STAT_NOTFOUND, 10'd0, 16'h0000);
    put_byte(8'hF0, CHK_MODEL, STAT_NOTFOUND, 10'd0, 16'h0000);
    put_byte(8'hFF, CHK_MODEL, STAT_NOTFOUND, 10'd0, 16'h0000);
    // overlong zero decodes to nothing
    put_byte(8'hC0, CHK_NONE, STAT_NOTFOUND, 10'd0, 16'h0000);
    put_byte(8'h80, CHK_NONE, STAT_NOTFOUND, 10'd0, 16'h0000);
    put_byte(8'hEF, CHK_NONE, STAT_NOTFOUND, 10'd0, 16'h0000);
    put_byte(8'hBF, CHK_NONE, STAT_NOTFOUND, 10'd0, 16'h0000);
    put_byte(8'hBF, CHK_HIT, STAT_NOTFOUND, 10'd0, 16'hFFFF);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].cmd, directed_rows[i].addr, directed_rows[i].code,
                directed_rows[i].bval, has_res, hit);
      case (directed_rows[i].chk)
        CHK_MODEL: if (has_res) expected_glyphs.push_back(hit);
        CHK_HIT:   expected_glyphs.push_back(directed_rows[i].hit);
        default:   ;
      endcase
    end

    // random phases, entry_count extremes included
    run_text_phase(11'd0, PACE_FREE, 50);
    run_text_phase(11'd1, PACE_SEND_IDLE, 60);
    run_text_phase(11'd7, PACE_RECV_STALL, 80);
    run_text_phase(11'd40, PACE_BOTH, 80);
    run_text_phase(11'd200, PACE_FREE, 60);
    run_text_phase(11'd1024, PACE_SEND_IDLE, 30);
    run_text_phase(11'd2047, PACE_RECV_STALL, 30);
    run_text_phase(11'd16, PACE_BOTH, 100);
    run_text_phase(11'd3, PACE_FREE, 60);

    in_valid <= 1'b0;
    while (expected_glyphs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
